>>> src/assert_macros.svh
// assertion macros used by the checker top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define PSC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define PSC_NEVER(lbl, clk, rst_n, cond, msg) \
    `PSC_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

>>> src/psc_pkg.sv
// constants shared by the pop sequence checker files
`timescale 1ns / 1ps

package psc_pkg;

    localparam int STACK_DEPTH_DEF = 1024;
    localparam int MAX_SEQ_LEN_DEF = 1024;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int VAL_W     = 11;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_LENGTH = 1'b1;

    localparam logic [CFG_W-1:0] CAPACITY_RST   = 11'd1024;
    localparam logic [CFG_W-1:0] SEQ_LENGTH_RST = 11'd1024;

endpackage

>>> src/pop_sequence_checker_unit.sv
// top level of the stack pop sequence checker
//
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   popped_value
//  m_axis    out        m_axis_tvalid/m_axis_tready   verdict
//  cfg       in         i_cfg_we                      capacity, seq_length
//
// a word is accepted, then handled one compare-and-push or pop step per cycle
// (pushes go through the stack ram write port, pops through its read port)
// a pop reads the new top from the ram, ready on the next accept cycle
// reset is synchronous and needs no clearing pass, stack entries are never
// read above the fill count; a verdict waits in the output register while
// new words are taken, the block stalls only if a second verdict is due
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pop_sequence_checker_unit
    import psc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int MAX_SEQ_LEN = MAX_SEQ_LEN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [10:0] popped_value
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // [0] verdict
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int FW = $clog2(STACK_DEPTH + 1);
    localparam int LW = $clog2(MAX_SEQ_LEN + 2);
    localparam int VW = $clog2(MAX_SEQ_LEN + 1);
    localparam int CW0 = (FW > LW) ? FW : LW;
    localparam int CW  = ((CW0 > CFG_W) ? CW0 : CFG_W) + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CHK  = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CFG_W-1:0] r_capacity, r_seq_length;
    logic [FW-1:0]    r_fill, n_fill;
    logic [LW-1:0]    r_next, n_next;
    logic [LW-1:0]    r_pos, n_pos;
    logic             r_failed, n_failed;
    logic             r_pend, n_pend;
    logic [VW-1:0]    r_top, n_top;
    logic [VAL_W-1:0] r_val, n_val;
    logic             r_out_valid, n_out_valid;
    logic             r_verdict, n_verdict;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_raddr;
    logic [VW-1:0] ram_rdata;

    logic [CW-1:0] w_cap_eff, w_len_eff;
    logic          w_full, w_exh, w_match, w_last, w_out_free;
    logic          w_done, w_fail;

    psc_ram #(
        .WIDTH (VW),
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (r_next[VW-1:0]),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // effective limits, saturated to the storage and length bounds, a zero length counts as one
    assign w_cap_eff = (CW'(r_capacity) > CW'(STACK_DEPTH)) ? CW'(STACK_DEPTH)
                                                            : CW'(r_capacity);
    always_comb begin
        if (r_seq_length == '0) begin
            w_len_eff = CW'(1);
        end else if (CW'(r_seq_length) > CW'(MAX_SEQ_LEN)) begin
            w_len_eff = CW'(MAX_SEQ_LEN);
        end else begin
            w_len_eff = CW'(r_seq_length);
        end
    end

    assign w_full     = CW'(r_fill) >= w_cap_eff;
    assign w_exh      = CW'(r_next) > w_len_eff;
    assign w_match    = (r_fill != '0) && (CW'(r_top) == CW'(r_val));
    assign w_last     = (CW'(r_pos) + CW'(1)) >= w_len_eff;
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign ram_raddr  = AW'(r_fill - FW'(2));

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_next      = r_next;
        n_pos       = r_pos;
        n_failed    = r_failed;
        n_pend      = r_pend;
        n_top       = r_top;
        n_val       = r_val;
        n_out_valid = r_out_valid;
        n_verdict   = r_verdict;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        w_done      = 1'b0;
        w_fail      = r_failed;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                // new top from the pop of the previous word
                if (r_pend) begin
                    n_top  = ram_rdata;
                    n_pend = 1'b0;
                end
                if (s_axis_tvalid) begin
                    n_val   = s_axis_tdata[VAL_W-1:0];
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_failed) begin
                    w_done = 1'b1;
                end else if (w_match) begin
                    n_fill = r_fill - FW'(1);
                    ram_re = 1'b1;
                    n_pend = 1'b1;
                    w_done = 1'b1;
                end else if (w_full || w_exh) begin
                    n_failed = 1'b1;
                    w_fail   = 1'b1;
                    w_done   = 1'b1;
                end else begin
                    ram_we = 1'b1;
                    n_top  = r_next[VW-1:0];
                    n_fill = r_fill + FW'(1);
                    n_next = r_next + LW'(1);
                end
                if (w_done) begin
                    n_pos   = r_pos + LW'(1);
                    n_state = S_IDLE;
                    if (w_last) begin
                        if (w_out_free) begin
                            n_out_valid = 1'b1;
                            n_verdict   = !w_fail;
                            n_fill      = '0;
                            n_next      = LW'(1);
                            n_pos       = '0;
                            n_failed    = 1'b0;
                            n_pend      = 1'b0;
                        end else begin
                            n_state = S_HOLD;
                        end
                    end
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_verdict   = !r_failed;
                    n_fill      = '0;
                    n_next      = LW'(1);
                    n_pos       = '0;
                    n_failed    = 1'b0;
                    n_pend      = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_capacity   <= CAPACITY_RST;
            r_seq_length <= SEQ_LENGTH_RST;
            r_fill       <= '0;
            r_next       <= LW'(1);
            r_pos        <= '0;
            r_failed     <= 1'b0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_next      <= n_next;
            r_pos       <= n_pos;
            r_failed    <= n_failed;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_CAPACITY:   r_capacity   <= i_cfg_data;
                    CFG_SEQ_LENGTH: r_seq_length <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top     <= n_top;
        r_val     <= n_val;
        r_verdict <= n_verdict;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'(r_verdict);

    // the fill count stays below the next value to push
    `PSC_ASSERT(a_fill_below_next, i_clk, i_rst_n, CW'(r_fill) < CW'(r_next), "fill count reached next push value")
    `PSC_NEVER(a_fill_in_depth, i_clk, i_rst_n, CW'(r_fill) > CW'(STACK_DEPTH), "fill count beyond stack depth")
    `PSC_ASSERT(a_push_grows, i_clk, i_rst_n, ram_we |=> (r_fill == $past(r_fill) + FW'(1)), "push did not grow the stack")
    `PSC_ASSERT(a_verdict_src, i_clk, i_rst_n, $rose(m_axis_tvalid) |-> ($past(r_state) == S_CHK || $past(r_state) == S_HOLD), "verdict without a finished word")

endmodule

>>> src/psc_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module psc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> bench/testbench.sv
// stack pop order checker testbench: directed and random sequences, scoreboard on verdicts
`timescale 1ns / 1ps

class pop_order_scoreboard;
    logic [psc_pkg::VAL_W-1:0] stack_mem [psc_pkg::STACK_DEPTH_DEF];
    int unsigned fill;
    int unsigned next_val;
    int unsigned pos;
    bit          seq_failed;
    logic [psc_pkg::CFG_W-1:0] capacity_reg;
    logic [psc_pkg::CFG_W-1:0] length_reg;
    bit          verdict_q [$];
    int unsigned errors;

    function new();
        capacity_reg = psc_pkg::CAPACITY_RST;
        length_reg   = psc_pkg::SEQ_LENGTH_RST;
        errors       = 0;
        clear_seq();
    endfunction

    function void clear_seq();
        fill       = 0;
        next_val   = 1;
        pos        = 0;
        seq_failed = 0;
    endfunction

    function void set_reg(logic [psc_pkg::CFG_IDX_W-1:0] idx, logic [psc_pkg::CFG_W-1:0] data);
        if (idx == psc_pkg::CFG_CAPACITY)
            capacity_reg = data;
        else if (idx == psc_pkg::CFG_SEQ_LENGTH)
            length_reg = data;
    endfunction

    function int unsigned eff_cap();
        return (capacity_reg > psc_pkg::STACK_DEPTH_DEF) ? psc_pkg::STACK_DEPTH_DEF
                                                          : capacity_reg;
    endfunction

    function int unsigned eff_len();
        int unsigned n;
        n = length_reg;
        if (n == 0) n = 1;
        if (n > psc_pkg::MAX_SEQ_LEN_DEF) n = psc_pkg::MAX_SEQ_LEN_DEF;
        return n;
    endfunction

    function bit push_next();
        if (fill >= eff_cap() || fill >= psc_pkg::STACK_DEPTH_DEF) return 0;
        if (next_val > eff_len()) return 0;
        stack_mem[fill] = next_val[psc_pkg::VAL_W-1:0];
        fill++;
        next_val++;
        return 1;
    endfunction

    // accepted word: advance the stack model, queue a verdict at sequence end
    function void note_popped(logic [psc_pkg::VAL_W-1:0] v);
        if (!seq_failed) begin
            if (fill == 0 && !push_next())
                seq_failed = 1;
            while (!seq_failed && stack_mem[fill-1] != v) begin
                if (!push_next())
                    seq_failed = 1;
            end
            if (!seq_failed)
                fill--;
        end
        pos++;
        if (pos >= eff_len()) begin
            verdict_q.push_back(!seq_failed);
            clear_seq();
        end
    endfunction

    function void check_verdict(logic actual);
        bit exp_v;
        if (verdict_q.size() == 0) begin
            $display("%0t verdict with nothing expected: expected none actual %0d",
                     $time, actual);
            errors++;
            return;
        end
        exp_v = verdict_q.pop_front();
        if (actual !== exp_v) begin
            $display("%0t verdict mismatch: expected %0d actual %0d", $time, exp_v, actual);
            errors++;
        end
    endfunction

    function int pending();
        return verdict_q.size();
    endfunction

    function void check_leftover();
        if (verdict_q.size() != 0) begin
            $display("%0t verdicts never seen: expected %0d more actual 0",
                     $time, verdict_q.size());
            errors++;
        end
    endfunction
endclass

module testbench;
    import psc_pkg::*;

    localparam int IDLE_LIMIT  = 20000;
    localparam int SETTLE_GAP  = 1100;   // one word may push up to a full stack
    localparam int TAIL_CYCLES = 1100;
    localparam int LONG_HOLD   = 600;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;    // [10:0] popped_value
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;    // [0] verdict
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    pop_order_scoreboard sb;
    logic [VAL_W-1:0]     seq_vals [$];
    int unsigned          burst_left;
    int unsigned          idle_cycles;
    int unsigned          hold_reqs;

    pop_sequence_checker_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // handshake monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_verdict(m_axis_tdata[0]);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_popped(s_axis_tdata[VAL_W-1:0]);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: changing stall rate, plus one long hold on request
    initial begin
        int unsigned stall_pct;
        int unsigned cnt;
        int unsigned holds_done;
        stall_pct  = 0;
        cnt        = 0;
        holds_done = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_reqs != holds_done) begin
                holds_done = hold_reqs;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge i_clk);
            end else begin
                if (cnt == 0) begin
                    cnt = $urandom_range(50, 250);
                    case ($urandom_range(0, 4))
                        0, 1:    stall_pct = 0;
                        2:       stall_pct = 25;
                        3:       stall_pct = 60;
                        default: stall_pct = 90;
                    endcase
                end
                cnt--;
                m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.set_reg(idx, data);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_word(logic [VAL_W-1:0] v);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'(v);
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
    endtask

    task automatic send_seq();
        foreach (seq_vals[k])
            send_word(seq_vals[k]);
    endtask

    // stop offering, wait for every verdict, then let the block go quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_GAP) @(posedge i_clk);
    endtask

    // random legal pop order under the given stack limit
    task automatic make_valid(int unsigned n, int unsigned cap);
        int unsigned stk [$];
        int unsigned nxt;
        seq_vals.delete();
        nxt = 1;
        while (seq_vals.size() < n) begin
            if (stk.size() > 0 && (nxt > n || stk.size() >= cap || $urandom_range(0, 1)))
                seq_vals.push_back(VAL_W'(stk.pop_back()));
            else if (nxt <= n && stk.size() < cap) begin
                stk.push_back(nxt);
                nxt++;
            end else
                break;
        end
        while (seq_vals.size() < n)
            seq_vals.push_back(VAL_W'($urandom_range(0, 2047)));
    endtask

    task automatic make_random_seq(int unsigned n, int unsigned cap);
        int unsigned a;
        int unsigned b;
        logic [VAL_W-1:0] t;
        case ($urandom_range(0, 9))
            0: begin
                seq_vals.delete();
                repeat (n) seq_vals.push_back(VAL_W'($urandom_range(0, 2047)));
            end
            1, 2: begin
                make_valid(n, cap);
                a = $urandom_range(0, n - 1);
                b = $urandom_range(0, n - 1);
                t = seq_vals[a];
                seq_vals[a] = seq_vals[b];
                seq_vals[b] = t;
            end
            3: begin
                make_valid(n, cap);
                seq_vals[$urandom_range(0, n - 1)] = ($urandom_range(0, 1) == 0)
                    ? VAL_W'($urandom_range(1, n)) : VAL_W'($urandom_range(0, 2047));
            end
            default: make_valid(n, cap);
        endcase
    endtask

    task automatic run_phase(logic [CFG_W-1:0] cap, logic [CFG_W-1:0] len,
                             int unsigned nseq, bit with_hold);
        int unsigned n;
        int unsigned c;
        write_reg(CFG_CAPACITY, cap);
        write_reg(CFG_SEQ_LENGTH, len);
        n = sb.eff_len();
        c = sb.eff_cap();
        if (with_hold) hold_reqs++;
        repeat (nseq) begin
            if (n > 100) make_valid(n, c);
            else make_random_seq(n, c);
            send_seq();
        end
        settle();
    endtask

    initial begin
        sb = new();
        burst_left    = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_CAPACITY;
        i_cfg_data    <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: in order, reversed, impossible order, zero value, top value
        write_reg(CFG_CAPACITY, 11'd4);
        write_reg(CFG_SEQ_LENGTH, 11'd4);
        seq_vals = '{11'd1, 11'd2, 11'd3, 11'd4};
        send_seq();
        seq_vals = '{11'd4, 11'd3, 11'd2, 11'd1};
        send_seq();
        seq_vals = '{11'd3, 11'd1, 11'd2, 11'd4};
        send_seq();
        seq_vals = '{11'd0, 11'd1, 11'd2, 11'd3};
        send_seq();
        seq_vals = '{11'd1, 11'd2, 11'd3, 11'd2047};
        send_seq();
        settle();
        // stack overflows before the deepest value is reached
        write_reg(CFG_CAPACITY, 11'd2);
        seq_vals = '{11'd4, 11'd3, 11'd2, 11'd1};
        send_seq();
        settle();
        // no room at all
        write_reg(CFG_CAPACITY, 11'd0);
        write_reg(CFG_SEQ_LENGTH, 11'd1);
        seq_vals = '{11'd1};
        send_seq();
        settle();

        run_phase(11'd1024, 11'd8,    15, 0);
        run_phase(11'd3,    11'd6,    20, 0);
        // length zero acts as one: a verdict per word, receiver holds off to fill up
        run_phase(11'd2047, 11'd0,    60, 1);
        run_phase(11'd1,    11'd5,    30, 0);
        run_phase(11'd0,    11'd3,    10, 0);
        run_phase(11'd20,   11'd50,    4, 0);
        run_phase(11'd2047, 11'd2047,  1, 0);
        run_phase(11'd1024, 11'd2,    10, 0);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        sb.check_leftover();
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
